// ===== design/fdf_pkg.sv =====
package fdf_pkg;

	localparam int unsigned DefColumns   = 16;
	localparam int unsigned DefRows      = 16;
	localparam int unsigned DefExtraRows = 3;

	localparam int unsigned LevelShift = 5;
	// Three 8x8 products add up to at most 195075, which needs 18 bits.
	localparam int unsigned SumW       = 18;

	// Configuration register indexes.
	localparam logic [1:0] RegSide   = 2'd0;
	localparam logic [1:0] RegCenter = 2'd1;
	localparam logic [1:0] RegDiv    = 2'd2;

	// Control beat from the front to the back.
	typedef struct packed {
		logic [7:0] rnd;
		logic [5:0] col;
		logic       bank;
	} job_t;

endpackage

// ===== design/fdf_front.sv =====
// Front part: accepts random bytes, tags each with its column and the old bank,
// and keeps a two-entry queue toward the back part.
module fdf_front #(
	parameter int unsigned COLUMNS = fdf_pkg::DefColumns
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          random_byte,
	output logic                job_valid,
	input  logic                job_take,
	output fdf_pkg::job_t       job
);
	import fdf_pkg::*;

	localparam int unsigned CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	job_t       q_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic [CW-1:0] col_q;
	logic       bank_q;
	logic       acc;

	assign in_stall  = (cnt_q == 2'd2);
	assign acc       = in_valid && !in_stall;
	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_q[rd_q];

	// Queue entries carry payload only.
	always_ff @(posedge clk) begin
		if (acc) begin
			q_q[wr_q].rnd  <= random_byte;
			q_q[wr_q].col  <= 6'(col_q);
			q_q[wr_q].bank <= bank_q;
		end
	end

	// Queue pointers and the column walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			rd_q   <= 1'b0;
			wr_q   <= 1'b0;
			col_q  <= '0;
			bank_q <= 1'b0;
		end else begin
			if (acc) begin
				wr_q <= !wr_q;
				if (32'(col_q) == COLUMNS - 1) begin
					col_q  <= '0;
					bank_q <= !bank_q;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (job_take && job_valid) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(job_take && job_valid);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !acc || (job_take && job_valid)) else $error("queue overflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid) else $error("take from empty queue");
`endif
endmodule

// ===== design/fdf_div.sv =====
// Restoring divider: one quotient bit per cycle over the 18-bit weighted sum.
module fdf_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [fdf_pkg::SumW-1:0] dividend,
	input  logic [7:0]               divisor,
	output logic                     busy,
	output logic [7:0]               quotient
);
	import fdf_pkg::*;

	localparam int unsigned CntW = $clog2(SumW + 1);

	logic [SumW-1:0] quo_q;
	logic [8:0]      rem_q;
	logic [7:0]      dvs_q;
	logic [CntW-1:0] cnt_q;
	logic [8:0]      trial;
	logic [9:0]      diff;

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q[7:0];
	assign trial    = {rem_q[7:0], quo_q[SumW-1]};
	assign diff     = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= (divisor == 8'd0) ? 8'd1 : divisor;
		end else if (busy) begin
			if (!diff[9]) begin
				rem_q <= diff[8:0];
				quo_q <= {quo_q[SumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[SumW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (start) cnt_q <= CntW'(SumW);
		else if (busy) cnt_q <= cnt_q - 1'b1;
	end
endmodule

// ===== design/fdf_back.sv =====
// Back part: walks one column row by row, reads three old bytes, divides,
// writes the new byte, stores the random byte in the last row, then streams the visible rows out.
module fdf_back #(
	parameter int unsigned COLUMNS    = fdf_pkg::DefColumns,
	parameter int unsigned ROWS       = fdf_pkg::DefRows,
	parameter int unsigned EXTRA_ROWS = fdf_pkg::DefExtraRows
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_take,
	input  fdf_pkg::job_t job,
	input  logic [7:0]    side_w,
	input  logic [7:0]    center_w,
	input  logic [7:0]    div_val,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [5:0]    column,
	output logic [5:0]    row,
	output logic [2:0]    level,
	output logic          last
);
	import fdf_pkg::*;

	localparam int unsigned Height = ROWS + EXTRA_ROWS;
	localparam int unsigned Bank   = COLUMNS * Height;
	localparam int unsigned Depth  = 2 * Bank;
	localparam int unsigned AW     = $clog2(Depth);
	localparam int unsigned RW     = $clog2(Height + 1);
	localparam int unsigned CW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int unsigned ClrW   = $clog2(Depth + 1);

	typedef enum logic [8:0] {
		S_CLR  = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_RDL  = 9'b000000100,
		S_RDC  = 9'b000001000,
		S_RDR  = 9'b000010000,
		S_SUM  = 9'b000100000,
		S_DIV  = 9'b001000000,
		S_RD   = 9'b010000000,
		S_OUT  = 9'b100000000
	} st_t;

	st_t           st_q;
	logic [7:0]    mem [Depth];
	logic [7:0]    rdata_q;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [ClrW-1:0] clr_q;
	logic [RW-1:0] r_q;
	job_t          job_q;
	logic [7:0]    lft_q;
	logic [15:0]   pl_q, pc_q;
	logic [SumW-1:0] sum_q;
	logic          div_start, div_busy, div_busy_q;
	logic [7:0]    quo;
	logic [CW-1:0] xc, xl, xr;
	logic          nb;
	logic          ovld_q;

	assign xc = job_q.col[CW-1:0];
	assign xl = (xc == '0) ? CW'(COLUMNS - 1) : xc - 1'b1;
	assign xr = (32'(xc) == COLUMNS - 1) ? '0 : xc + 1'b1;
	assign nb = !job_q.bank;

	function automatic logic [AW-1:0] addr(logic b, logic [CW-1:0] x, logic [RW-1:0] r);
		return AW'(32'(b) * Bank + 32'(x) * Height + 32'(r));
	endfunction

	// Read address per state: left, center, then right neighbor one row down; the new row for output.
	always_comb begin
		case (st_q)
			S_IDLE:  raddr = addr(nb, xc, r_q);
			S_RDL:   raddr = addr(job_q.bank, xl, r_q + 1'b1);
			S_RDC:   raddr = addr(job_q.bank, xc, r_q + 1'b1);
			S_RDR:   raddr = addr(job_q.bank, xr, r_q + 1'b1);
			S_RD:    raddr = addr(nb, xc, r_q);
			default: raddr = addr(job_q.bank, xl, r_q + 1'b1);
		endcase
	end

	// The divider starts in the first divide cycle, once the sum has settled.
	assign div_start = (st_q == S_DIV) && !div_busy && !div_busy_q;
	assign we    = (st_q == S_CLR) || (st_q == S_DIV && !div_busy && div_busy_q)
	               || (st_q == S_IDLE && job_valid && 32'(r_q) == Height - 1);
	assign waddr = (st_q == S_CLR) ? AW'(clr_q) : addr(nb, xc, r_q);
	assign wdata = (st_q == S_CLR) ? 8'd0 : ((st_q == S_IDLE) ? job.rnd : quo);

	// Field memory.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	fdf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_q),
		.divisor(div_val), .busy(div_busy), .quotient(quo)
	);

	// Products and sum.
	always_ff @(posedge clk) begin
		if (st_q == S_RDC) lft_q <= rdata_q;
		if (st_q == S_RDR) begin
			pl_q <= side_w * lft_q;
			pc_q <= center_w * rdata_q;
		end
		if (st_q == S_SUM) sum_q <= SumW'(pl_q) + SumW'(pc_q) + SumW'(side_w * rdata_q);
		if (st_q == S_IDLE && job_valid) job_q <= job;
	end

	assign job_take = 1'b0 | (st_q == S_IDLE && job_valid && 32'(r_q) == Height - 1);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_CLR;
			clr_q      <= '0;
			r_q        <= '0;
			ovld_q     <= 1'b0;
			div_busy_q <= 1'b0;
			row        <= '0;
			last       <= 1'b0;
			column     <= '0;
			level      <= '0;
		end else begin
			div_busy_q <= div_busy;
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == Depth - 1) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (job_valid) begin
						if (32'(r_q) == Height - 1) begin
							r_q  <= '0;
							st_q <= S_RD;
						end else begin
							st_q <= S_RDL;
						end
					end
				end
				S_RDL: st_q <= S_RDC;
				S_RDC: st_q <= S_RDR;
				S_RDR: st_q <= S_SUM;
				S_SUM: st_q <= S_DIV;
				S_DIV: if (!div_busy && div_busy_q) begin
					r_q  <= r_q + 1'b1;
					st_q <= S_IDLE;
				end
				S_RD: begin
					if (!ovld_q || !out_stall) begin
						st_q   <= S_OUT;
					end
				end
				S_OUT: begin
					ovld_q <= 1'b1;
					if (32'(r_q) == ROWS - 1) st_q <= S_IDLE;
					else st_q <= S_RD;
					row    <= 6'(r_q);
					last   <= (32'(r_q) == ROWS - 1);
					column <= job_q.col;
					level  <= rdata_q[7:LevelShift];
					r_q    <= (32'(r_q) == ROWS - 1) ? '0 : r_q + 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
			if (ovld_q && !out_stall && st_q != S_OUT) ovld_q <= 1'b0;
		end
	end

	assign out_valid = ovld_q;

`ifndef ASSERT_OFF
	a_out_one_per_row: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_OUT |-> !ovld_q || !out_stall) else $error("output beat overwritten");
	a_take_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> st_q == S_IDLE) else $error("job taken outside idle");
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy) else $error("divider did not start");
`endif
endmodule

// ===== design/fire_diffusion_field.sv =====
// Each computed row steps through idle, three reads (left, center, right), a sum and the divider;
// then the column's visible rows are read back and streamed out, which output stalls can hold.
// Throughput: one item per column walk; the bit-serial divider dominates it.
// A two-beat queue lets random bytes arrive while a column is in progress.
// Reset is asynchronous, active low; afterwards a clearing pass zeroes the field,
// during which at most two beats are queued.
module fire_diffusion_field #(
	parameter int unsigned COLUMNS    = fdf_pkg::DefColumns,
	parameter int unsigned ROWS       = fdf_pkg::DefRows,
	parameter int unsigned EXTRA_ROWS = fdf_pkg::DefExtraRows
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] random_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [5:0] column,
	output logic [5:0] row,
	output logic [2:0] level,
	output logic       last
);
	import fdf_pkg::*;

	logic [7:0] side_q, center_q, div_q;
	logic       job_valid, job_take;
	job_t       job;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q   <= 8'd1;
			center_q <= 8'd2;
			div_q    <= 8'd4;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegSide:   side_q   <= cfg_data;
				RegCenter: center_q <= cfg_data;
				RegDiv:    div_q    <= cfg_data;
				default:   ;
			endcase
		end
	end

	fdf_front #(.COLUMNS(COLUMNS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.random_byte(random_byte), .job_valid(job_valid), .job_take(job_take), .job(job)
	);

	fdf_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .EXTRA_ROWS(EXTRA_ROWS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_take(job_take), .job(job),
		.side_w(side_q), .center_w(center_q), .div_val(div_q),
		.out_valid(out_valid), .out_stall(out_stall), .column(column), .row(row),
		.level(level), .last(last)
	);
endmodule
